// ===== src/bhgr_pkg.sv =====
// ----------------------------------------------------------------------------
// bhgr_pkg
// Shared widths, record and result types, register indexes, reset values and
// queue depths for the best hit group reducer.
// ----------------------------------------------------------------------------
package bhgr_pkg;

    localparam int ID_W    = 32;
    localparam int TAXON_W = 16;
    localparam int MANT_W  = 20;
    localparam int EXP_W   = 11;
    localparam int PCT_W   = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CUTOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_MANT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_EXP     = 2'd2;

    localparam logic [PCT_W-1:0]  RST_MATCH_CUTOFF = 15'd12800;
    localparam logic [MANT_W-1:0] RST_EVAL_MANT    = 20'd65536;
    localparam logic [EXP_W-1:0]  RST_EVAL_EXP     = 11'h7FB;

    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 4;

    // classified record as it crosses from front to back
    typedef struct packed {
        logic [ID_W-1:0]    query;
        logic [ID_W-1:0]    subject;
        logic [TAXON_W-1:0] query_taxon;
        logic [TAXON_W-1:0] subject_taxon;
        logic [MANT_W-1:0]  mant;
        logic [EXP_W-1:0]   expo;
        logic               qual;
        logic               eos;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]    group_query;
        logic [TAXON_W-1:0] group_query_taxon;
        logic [TAXON_W-1:0] group_subject_taxon;
        logic [ID_W-1:0]    best_subject;
        logic [MANT_W-1:0]  best_mantissa;
        logic [EXP_W-1:0]   best_exponent;
        logic               unique_res;
        logic               final_res;
    } t_result;

endpackage

// ===== src/bhgr_fifo.sv =====
// ----------------------------------------------------------------------------
// bhgr_fifo
// Small register queue of classified records between front and back.
// ----------------------------------------------------------------------------
module bhgr_fifo
    import bhgr_pkg::*;
#(
    parameter int DEPTH = IN_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/bhgr_front.sv =====
// ----------------------------------------------------------------------------
// bhgr_front
// Holds the cutoff registers and classifies each incoming record.
// ----------------------------------------------------------------------------
module bhgr_front
    import bhgr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ID_W-1:0]       i_query,
    input  logic [ID_W-1:0]       i_subject,
    input  logic [TAXON_W-1:0]    i_query_taxon,
    input  logic [TAXON_W-1:0]    i_subject_taxon,
    input  logic [MANT_W-1:0]     i_evalue_mantissa,
    input  logic [EXP_W-1:0]      i_evalue_exponent,
    input  logic [PCT_W-1:0]      i_percent_match,
    input  logic                  i_end_of_stream,
    output t_item                 o_item
);

    logic [PCT_W-1:0]  r_match_cutoff;
    logic [MANT_W-1:0] r_eval_mant;
    logic [EXP_W-1:0]  r_eval_exp;
    logic              ev_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_cutoff <= RST_MATCH_CUTOFF;
            r_eval_mant    <= RST_EVAL_MANT;
            r_eval_exp     <= RST_EVAL_EXP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MATCH_CUTOFF: r_match_cutoff <= i_cfg_data[PCT_W-1:0];
                CFG_EVAL_MANT:    r_eval_mant    <= i_cfg_data[MANT_W-1:0];
                CFG_EVAL_EXP:     r_eval_exp     <= i_cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // zero mantissa is an e-value of zero and always passes
    always_comb begin
        if (i_evalue_mantissa == '0) begin
            ev_pass = 1'b1;
        end else if (i_evalue_exponent != r_eval_exp) begin
            ev_pass = $signed(i_evalue_exponent) < $signed(r_eval_exp);
        end else begin
            ev_pass = (i_evalue_mantissa <= r_eval_mant);
        end
    end

    always_comb begin
        o_item.query         = i_query;
        o_item.subject       = i_subject;
        o_item.query_taxon   = i_query_taxon;
        o_item.subject_taxon = i_subject_taxon;
        o_item.mant          = i_evalue_mantissa;
        o_item.expo          = i_evalue_exponent;
        o_item.qual          = (i_query_taxon != i_subject_taxon) &&
                               (i_percent_match >= r_match_cutoff) && ev_pass;
        o_item.eos           = i_end_of_stream;
    end

endmodule

// ===== src/bhgr_back.sv =====
// ----------------------------------------------------------------------------
// bhgr_back
// Group tracker: retires one classified record per cycle while the result queue
// has room for two results, closes groups and writes up to two results per record.
// ----------------------------------------------------------------------------
module bhgr_back
    import bhgr_pkg::*;
#(
    parameter int DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_empty,
    input  t_item   i_item,
    output logic    o_in_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_CNT = CNT_W'(DEPTH - 2);

    // group state
    logic               r_open, n_open;
    logic [ID_W-1:0]    r_cur_q, n_cur_q;
    logic [TAXON_W-1:0] r_cur_qt, n_cur_qt;
    logic [TAXON_W-1:0] r_cur_st, n_cur_st;
    logic               r_have, n_have;
    logic [ID_W-1:0]    r_best_s, n_best_s;
    logic [MANT_W-1:0]  r_best_m, n_best_m;
    logic [EXP_W-1:0]   r_best_e, n_best_e;
    logic               r_uniq, n_uniq;

    // result queue
    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_ptr_2nd;

    logic    take, key_chg, keep_open, emit_old, emit_new, do_pop;
    logic    wr_a, wr_b;
    t_result res_old, res_new, wdata_a;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign take     = !i_in_empty && (r_count <= ROOM_CNT);
    assign o_in_pop = take;
    assign key_chg  = r_open && ((i_item.query != r_cur_q) ||
                                 (i_item.subject_taxon != r_cur_st));
    assign keep_open = r_open && !key_chg;
    assign emit_old = take && key_chg && r_have;

    always_comb begin
        n_cur_q  = keep_open ? r_cur_q  : i_item.query;
        n_cur_qt = keep_open ? r_cur_qt : i_item.query_taxon;
        n_cur_st = keep_open ? r_cur_st : i_item.subject_taxon;
        n_have   = keep_open && r_have;
        n_uniq   = keep_open && r_uniq;
        n_best_s = r_best_s;
        n_best_m = r_best_m;
        n_best_e = r_best_e;
        if (i_item.qual) begin
            if (!n_have) begin
                n_have   = 1'b1;
                n_uniq   = 1'b1;
                n_best_s = i_item.subject;
                n_best_m = i_item.mant;
                n_best_e = i_item.expo;
            end else if (i_item.expo == r_best_e && i_item.mant == r_best_m &&
                         i_item.subject != r_best_s) begin
                n_uniq = 1'b0;
            end
        end
        n_open   = !i_item.eos;
        emit_new = take && i_item.eos && n_have;
    end

    always_comb begin
        res_old.group_query         = r_cur_q;
        res_old.group_query_taxon   = r_cur_qt;
        res_old.group_subject_taxon = r_cur_st;
        res_old.best_subject        = r_best_s;
        res_old.best_mantissa       = r_best_m;
        res_old.best_exponent       = r_best_e;
        res_old.unique_res          = r_uniq;
        res_old.final_res           = !emit_new;

        res_new.group_query         = n_cur_q;
        res_new.group_query_taxon   = n_cur_qt;
        res_new.group_subject_taxon = n_cur_st;
        res_new.best_subject        = n_best_s;
        res_new.best_mantissa       = n_best_m;
        res_new.best_exponent       = n_best_e;
        res_new.unique_res          = n_uniq;
        res_new.final_res           = 1'b1;
    end

    // first write slot gets the older group when there is one
    assign wr_a       = emit_old || emit_new;
    assign wr_b       = emit_old && emit_new;
    assign wdata_a    = emit_old ? res_old : res_new;
    assign wr_ptr_2nd = ptr_inc(r_wr_ptr);

    assign o_empty = (r_count == '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_b) begin
            n_wr_ptr = ptr_inc(wr_ptr_2nd);
        end else if (wr_a) begin
            n_wr_ptr = wr_ptr_2nd;
        end
        if (do_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
        end
        n_count = r_count + CNT_W'(wr_a) + CNT_W'(wr_b) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_have   <= 1'b0;
            r_uniq   <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (take) begin
                r_open <= n_open;
                r_have <= n_open && n_have;
                r_uniq <= n_open && n_uniq;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur_q  <= n_cur_q;
            r_cur_qt <= n_cur_qt;
            r_cur_st <= n_cur_st;
            r_best_s <= n_best_s;
            r_best_m <= n_best_m;
            r_best_e <= n_best_e;
        end
        if (wr_a) begin
            r_mem[r_wr_ptr] <= wdata_a;
        end
        if (wr_b) begin
            r_mem[wr_ptr_2nd] <= res_new;
        end
    end

endmodule

// ===== src/best_hit_group_reducer.sv =====
// ----------------------------------------------------------------------------
// best_hit_group_reducer
// Reduces a sorted stream of similarity records to one best hit per group.
// ----------------------------------------------------------------------------
// Accepts one record per clock whenever full is low. Each record is checked
// against the cutoffs on entry and written to a record queue of IN_DEPTH
// entries; the group tracker retires one record per clock while the result
// queue (OUT_DEPTH entries, at least 2) has room for two results, so the
// sustained rate is one record per cycle as long as results are popped. A
// result reaches the output ports after the record that closes its group has
// passed the record queue and the tracker has written it to the result queue.
// A group is closed by a key change (query or subject taxon) or by a record
// marked end of stream; a record with both closes two groups and gives up to two
// results, final_res set on the last. Cutoff registers are written through the cfg
// port, which is always ready; write them only while no records are in flight.
// ----------------------------------------------------------------------------
module best_hit_group_reducer
    import bhgr_pkg::*;
#(
    parameter int IN_DEPTH  = IN_QUEUE_DEPTH,
    parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [ID_W-1:0]       i_query,
    input  logic [ID_W-1:0]       i_subject,
    input  logic [TAXON_W-1:0]    i_query_taxon,
    input  logic [TAXON_W-1:0]    i_subject_taxon,
    input  logic [MANT_W-1:0]     i_evalue_mantissa,
    input  logic [EXP_W-1:0]      i_evalue_exponent,
    input  logic [PCT_W-1:0]      i_percent_match,
    input  logic                  i_end_of_stream,
    output logic                  empty,
    input  logic                  pop,
    output logic [ID_W-1:0]       o_group_query,
    output logic [TAXON_W-1:0]    o_group_query_taxon,
    output logic [TAXON_W-1:0]    o_group_subject_taxon,
    output logic [ID_W-1:0]       o_best_subject,
    output logic [MANT_W-1:0]     o_best_mantissa,
    output logic [EXP_W-1:0]      o_best_exponent,
    output logic                  o_unique_res,
    output logic                  o_final_res
);

    t_item   front_item, q_item;
    logic    q_empty, q_pop;
    t_result res;

    assign o_cfg_ready = 1'b1;

    bhgr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_query           (i_query),
        .i_subject         (i_subject),
        .i_query_taxon     (i_query_taxon),
        .i_subject_taxon   (i_subject_taxon),
        .i_evalue_mantissa (i_evalue_mantissa),
        .i_evalue_exponent (i_evalue_exponent),
        .i_percent_match   (i_percent_match),
        .i_end_of_stream   (i_end_of_stream),
        .o_item            (front_item)
    );

    bhgr_fifo #(
        .DEPTH (IN_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    bhgr_back #(
        .DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (q_empty),
        .i_item     (q_item),
        .o_in_pop   (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_group_query         = res.group_query;
    assign o_group_query_taxon   = res.group_query_taxon;
    assign o_group_subject_taxon = res.group_subject_taxon;
    assign o_best_subject        = res.best_subject;
    assign o_best_mantissa       = res.best_mantissa;
    assign o_best_exponent       = res.best_exponent;
    assign o_unique_res          = res.unique_res;
    assign o_final_res           = res.final_res;

endmodule

// ===== tb/best_hit_group_reducer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_hit_group_reducer_tb
// Streams similarity records through the reducer and checks every emitted
// best hit against a cycle-free predictor of the grouping rules. A short
// directed set covers the cutoff edges, ties, key changes and end of stream.
// Random groups with content near the cutoffs and some noise follow, over
// several cutoff settings and three idling profiles.
// ----------------------------------------------------------------------------
module best_hit_group_reducer_tb;
    import bhgr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [EXP_W-1:0] EXP_M4 = 11'h7FC;
    localparam logic [EXP_W-1:0] EXP_M5 = 11'h7FB;
    localparam logic [EXP_W-1:0] EXP_M6 = 11'h7FA;
    localparam logic [EXP_W-1:0] EXP_M10 = 11'h7F6;

    typedef struct packed {
        logic [ID_W-1:0]    query;
        logic [ID_W-1:0]    subject;
        logic [TAXON_W-1:0] query_taxon;
        logic [TAXON_W-1:0] subject_taxon;
        logic [MANT_W-1:0]  mant;
        logic [EXP_W-1:0]   expo;
        logic [PCT_W-1:0]   pct;
        logic               eos;
    } t_rec;

    logic i_clk;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_cfg_ready;

    logic push_r = 1'b0;
    logic full;
    t_rec drv_rec = '0;
    logic empty;
    logic pop_r = 1'b0;

    logic [ID_W-1:0]    o_group_query;
    logic [TAXON_W-1:0] o_group_query_taxon;
    logic [TAXON_W-1:0] o_group_subject_taxon;
    logic [ID_W-1:0]    o_best_subject;
    logic [MANT_W-1:0]  o_best_mantissa;
    logic [EXP_W-1:0]   o_best_exponent;
    logic               o_unique_res;
    logic               o_final_res;

    // cutoff mirror
    logic [PCT_W-1:0]  cut_pct = RST_MATCH_CUTOFF;
    logic [MANT_W-1:0] cut_mant = RST_EVAL_MANT;
    logic [EXP_W-1:0]  cut_exp = RST_EVAL_EXP;

    // group tracker mirror
    logic               grp_open = 1'b0;
    logic [ID_W-1:0]    grp_query = '0;
    logic [TAXON_W-1:0] grp_qtaxon = '0;
    logic [TAXON_W-1:0] grp_staxon = '0;
    logic               grp_has_best = 1'b0;
    logic [ID_W-1:0]    best_subj = '0;
    logic [MANT_W-1:0]  best_mant = '0;
    logic [EXP_W-1:0]   best_exp = '0;
    logic               best_unique = 1'b0;

    t_rec    record_q[$];
    t_result closed_q[$];
    t_result best_hit_q[$];

    int send_idle_pct = 30;
    int recv_idle_pct = 48;
    int fail_cnt = 0;
    int queued_total = 0;
    logic [ID_W-1:0] gen_query = '0;

    best_hit_group_reducer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (rst_n),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .push                  (push_r),
        .full                  (full),
        .i_query               (drv_rec.query),
        .i_subject             (drv_rec.subject),
        .i_query_taxon         (drv_rec.query_taxon),
        .i_subject_taxon       (drv_rec.subject_taxon),
        .i_evalue_mantissa     (drv_rec.mant),
        .i_evalue_exponent     (drv_rec.expo),
        .i_percent_match       (drv_rec.pct),
        .i_end_of_stream       (drv_rec.eos),
        .empty                 (empty),
        .pop                   (pop_r),
        .o_group_query         (o_group_query),
        .o_group_query_taxon   (o_group_query_taxon),
        .o_group_subject_taxon (o_group_subject_taxon),
        .o_best_subject        (o_best_subject),
        .o_best_mantissa       (o_best_mantissa),
        .o_best_exponent       (o_best_exponent),
        .o_unique_res          (o_unique_res),
        .o_final_res           (o_final_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    task automatic close_group();
        t_result res;
        if (grp_open && grp_has_best) begin
            res.group_query         = grp_query;
            res.group_query_taxon   = grp_qtaxon;
            res.group_subject_taxon = grp_staxon;
            res.best_subject        = best_subj;
            res.best_mantissa       = best_mant;
            res.best_exponent       = best_exp;
            res.unique_res          = best_unique;
            res.final_res           = 1'b0;
            closed_q.push_back(res);
        end
        grp_open     = 1'b0;
        grp_has_best = 1'b0;
        best_subj    = '0;
        best_mant    = '0;
        best_exp     = '0;
        best_unique  = 1'b0;
    endtask

    task automatic reduce_record(input t_rec r);
        logic    evalue_ok;
        logic    qual;
        t_result tail_res;
        if (grp_open && (r.query != grp_query || r.subject_taxon != grp_staxon))
            close_group();
        if (!grp_open) begin
            grp_open     = 1'b1;
            grp_query    = r.query;
            grp_qtaxon   = r.query_taxon;
            grp_staxon   = r.subject_taxon;
            grp_has_best = 1'b0;
            best_unique  = 1'b0;
        end
        if (r.mant == '0)
            evalue_ok = 1'b1;
        else if (r.expo != cut_exp)
            evalue_ok = $signed(r.expo) < $signed(cut_exp);
        else
            evalue_ok = r.mant <= cut_mant;
        qual = (r.query_taxon != r.subject_taxon) && (r.pct >= cut_pct) && evalue_ok;
        if (qual) begin
            if (!grp_has_best) begin
                grp_has_best = 1'b1;
                best_subj    = r.subject;
                best_mant    = r.mant;
                best_exp     = r.expo;
                best_unique  = 1'b1;
            end else if (r.expo == best_exp && r.mant == best_mant &&
                         r.subject != best_subj) begin
                best_unique = 1'b0;
            end
        end
        if (r.eos)
            close_group();
        if (closed_q.size() != 0) begin
            tail_res = closed_q.pop_back();
            tail_res.final_res = 1'b1;
            closed_q.push_back(tail_res);
        end
        while (closed_q.size() != 0)
            best_hit_q.push_back(closed_q.pop_front());
    endtask

    // ------------------------------------------------------------------------
    // record driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            push_r <= 1'b0;
        end else begin
            if (push_r && !full)
                reduce_record(drv_rec);
            if (push_r && full) begin
                // hold the record until the transfer
            end else if (record_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_rec <= record_q.pop_front();
                push_r  <= 1'b1;
            end else begin
                push_r <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    task automatic check_best_hit();
        t_result got;
        t_result want;
        got = {o_group_query, o_group_query_taxon, o_group_subject_taxon, o_best_subject,
               o_best_mantissa, o_best_exponent, o_unique_res, o_final_res};
        if (best_hit_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("%0t: result with none expected: q=%h qt=%h st=%h subj=%h",
                         $realtime, got.group_query, got.group_query_taxon,
                         got.group_subject_taxon, got.best_subject);
        end else begin
            want = best_hit_q.pop_front();
            if (got !== want) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("%0t: mismatch exp q=%h qt=%h st=%h subj=%h m=%h e=%h u=%b f=%b",
                             $realtime, want.group_query, want.group_query_taxon,
                             want.group_subject_taxon, want.best_subject,
                             want.best_mantissa, want.best_exponent,
                             want.unique_res, want.final_res);
                    $display("%0t:          act q=%h qt=%h st=%h subj=%h m=%h e=%h u=%b f=%b",
                             $realtime, got.group_query, got.group_query_taxon,
                             got.group_subject_taxon, got.best_subject,
                             got.best_mantissa, got.best_exponent,
                             got.unique_res, got.final_res);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!rst_n) begin
            pop_r <= 1'b0;
        end else begin
            if (pop_r && !empty)
                check_best_hit();
            pop_r <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic t_rec mk(input logic [ID_W-1:0] q, input logic [ID_W-1:0] s,
                                input logic [TAXON_W-1:0] qt, input logic [TAXON_W-1:0] st,
                                input logic [MANT_W-1:0] m, input logic [EXP_W-1:0] e,
                                input logic [PCT_W-1:0] p, input logic eos);
        t_rec r;
        r = '{q, s, qt, st, m, e, p, eos};
        return r;
    endfunction

    task automatic add_record(input t_rec r);
        record_q.push_back(r);
        queued_total++;
    endtask

    task automatic pick_evalue(output logic [MANT_W-1:0] m, output logic [EXP_W-1:0] e);
        case ($urandom_range(5))
            0: begin
                m = '0;
                e = EXP_W'($urandom);
            end
            1: begin
                e = cut_exp;
                m = cut_mant + MANT_W'($urandom_range(4)) - MANT_W'(2);
            end
            2: begin
                e = cut_exp - EXP_W'(1);
                m = MANT_W'($urandom);
            end
            3: begin
                e = cut_exp + EXP_W'(1);
                m = MANT_W'($urandom);
            end
            default: begin
                e = EXP_W'($urandom);
                m = MANT_W'($urandom);
            end
        endcase
    endtask

    // one well-formed group with random content, or a noise record
    task automatic queue_group();
        t_rec               r;
        int                 len;
        logic [TAXON_W-1:0] st;
        logic [TAXON_W-1:0] qt;
        logic [ID_W-1:0]    subj;
        logic [MANT_W-1:0]  m;
        logic [EXP_W-1:0]   e;
        if ($urandom_range(99) < 10) begin
            r.query         = $urandom;
            r.subject       = $urandom;
            r.query_taxon   = TAXON_W'($urandom);
            r.subject_taxon = TAXON_W'($urandom);
            r.mant          = MANT_W'($urandom);
            r.expo          = EXP_W'($urandom);
            r.pct           = PCT_W'($urandom);
            r.eos           = ($urandom_range(49) == 0);
            add_record(r);
            return;
        end
        if ($urandom_range(19) == 0)
            gen_query = $urandom;
        else if ($urandom_range(3) != 0)
            gen_query = gen_query + ID_W'($urandom_range(1, 3));
        st = ($urandom_range(3) == 0) ? TAXON_W'($urandom) : TAXON_W'($urandom_range(7));
        qt = ($urandom_range(9) == 0) ? st : st ^ TAXON_W'($urandom_range(1, 65535));
        len = $urandom_range(1, 5);
        subj = $urandom;
        pick_evalue(m, e);
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                if ($urandom_range(9) >= 4)
                    pick_evalue(m, e);
                if ($urandom_range(1) == 0)
                    subj = $urandom;
            end
            r.query         = gen_query;
            r.subject       = subj;
            r.query_taxon   = qt;
            r.subject_taxon = st;
            r.mant          = m;
            r.expo          = e;
            r.pct = ($urandom_range(9) < 8) ? PCT_W'($urandom_range(32767, cut_pct))
                                            : PCT_W'($urandom);
            r.eos = (i == len - 1) && ($urandom_range(29) == 0);
            add_record(r);
        end
    endtask

    task automatic queue_random(input int n);
        int target;
        target = queued_total + n;
        while (queued_total < target)
            queue_group();
    endtask

    task automatic queue_directed();
        // taxa equal, then key change closes a group that never had a best hit
        add_record(mk(0, 0, 0, 0, 0, 0, 0, 0));
        add_record(mk(1, 10, 1, 2, 20'h10000, EXP_M5, 15'd12799, 0));
        // mantissa equal to cutoff at cutoff exponent, then a tie from another subject
        add_record(mk(1, 11, 1, 2, 20'h10000, EXP_M5, 15'd12800, 0));
        add_record(mk(1, 12, 1, 2, 20'h10000, EXP_M5, 15'd14000, 0));
        add_record(mk(1, 13, 1, 2, 20'h10001, EXP_M5, 15'd25600, 0));
        // zero mantissa passes at the largest exponent; same-subject tie keeps unique
        add_record(mk(2, 20, 5, 2, 0, 11'h3FF, 15'd25600, 0));
        add_record(mk(2, 20, 5, 2, 0, 11'h3FF, 15'd25600, 0));
        add_record(mk(2, 21, 6, 3, 20'h10001, EXP_M5, 15'd25600, 0));
        add_record(mk(2, 22, 6, 3, 20'hFFFFF, EXP_M6, 15'd25600, 0));
        add_record(mk(2, 23, 7, 3, 20'hFFFFF, EXP_M4, 15'd25600, 0));
        add_record(mk(2, 24, 3, 3, 0, 0, 15'd25600, 0));
        // key change with end of stream: two results
        add_record(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 0, 20'hFFFFF, 11'h400,
                      15'h7FFF, 1));
        add_record(mk(32'hFFFFFFFF, 5, 16'hFFFF, 0, 20'h00001, 11'h400, 15'h7FFF, 1));
        // end of stream on a group without a best hit
        add_record(mk(3, 30, 1, 16'hFFFF, 20'h10000, 11'h005, 15'd25600, 1));
        // unsorted: key 4 comes back after key 5
        add_record(mk(4, 40, 1, 9, 20'h08000, EXP_M5, 15'd12800, 0));
        add_record(mk(5, 50, 1, 9, 20'h08000, EXP_M5, 15'd12800, 0));
        add_record(mk(4, 41, 1, 9, 20'h08000, EXP_M5, 15'd12800, 1));
        // tie with the best after a different qualifying e-value
        add_record(mk(6, 60, 2, 1, 20'h10000, EXP_M5, 15'd12800, 0));
        add_record(mk(6, 61, 2, 1, 20'h10000, EXP_M6, 15'd12800, 0));
        add_record(mk(6, 62, 2, 1, 20'h10000, EXP_M5, 15'd12800, 0));
        add_record(mk(6, 63, 2, 1, 20'h10000, EXP_M5, 15'd12799, 1));
        add_record(mk(7, 70, 0, 16'hFFFF, 0, 11'h7FF, 15'h7FFF, 0));
        add_record(mk(7, 70, 0, 16'hFFFF, 0, 11'h7FF, 15'h0000, 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MATCH_CUTOFF: cut_pct  = val[PCT_W-1:0];
            CFG_EVAL_MANT:    cut_mant = val[MANT_W-1:0];
            CFG_EVAL_EXP:     cut_exp  = val[EXP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cutoffs(input logic [PCT_W-1:0] p, input logic [MANT_W-1:0] m,
                               input logic [EXP_W-1:0] e);
        write_reg(CFG_MATCH_CUTOFF, CFG_DATA_W'(p));
        write_reg(CFG_EVAL_MANT, CFG_DATA_W'(m));
        write_reg(CFG_EVAL_EXP, CFG_DATA_W'(e));
    endtask

    // sender holds off until everything in flight has come out
    task automatic drain();
        do @(negedge i_clk);
        while (record_q.size() != 0 || push_r || best_hit_q.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    initial begin
        @(posedge rst_n);
        @(negedge i_clk);
        queue_directed();
        queue_random(180);
        for (int ph = 1; ph < 7; ph++) begin
            drain();
            if (ph == 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 30;
            end else if (ph == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: set_cutoffs(15'd0, 20'hFFFFF, 11'h3FF);
                2: begin
                    set_cutoffs(15'd25600, 20'd0, 11'h400);
                    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
                end
                3: set_cutoffs(15'h7FFF, 20'd655359, 11'h000);
                4: set_cutoffs(PCT_W'($urandom_range(25600)), MANT_W'($urandom_range(655359)),
                               EXP_W'($urandom));
                5: set_cutoffs(15'd6400, 20'h10000, EXP_M10);
                default: set_cutoffs(RST_MATCH_CUTOFF, RST_EVAL_MANT, RST_EVAL_EXP);
            endcase
            @(negedge i_clk);
            queue_random(200);
        end
        drain();
        if (fail_cnt == 0 && best_hit_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
